### src/sfq_pkg.sv
// Shared types and codes for the searchable FIFO queue.
`default_nettype none

package sfq_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef enum logic [1:0] {
        REQ_ENQUEUE = 2'd0,
        REQ_DEQUEUE = 2'd1,
        REQ_SEARCH  = 2'd2,
        REQ_READOUT = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE    = 2'd0,
        BK_DEQUEUE = 2'd1,
        BK_SEARCH  = 2'd2,
        BK_READOUT = 2'd3
    } back_state_t;

    typedef struct packed {
        req_kind_t                  kind;
        logic signed [VALUE_W-1:0]  value;
    } req_t;

endpackage

`default_nettype wire

### src/sfq_front.sv
// Request intake: accepts stream transfers, decodes the request kind and queues it.
`default_nettype none

module sfq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [sfq_pkg::VALUE_W-1:0]  s_axis_tdata,   // item_value
    input  logic [1:0]                          s_axis_tuser,   // req_type
    output logic                                q_valid,
    input  logic                                q_pop,
    output sfq_pkg::req_t                       q_req
);
    import sfq_pkg::*;

    req_t        slot_mem [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign pop           = q_pop && q_valid;
    assign q_req         = slot_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_mem[wr_ptr_reg].kind  <= req_kind_t'(s_axis_tuser);
            slot_mem[wr_ptr_reg].value <= s_axis_tdata;
        end
    end

endmodule

`default_nettype wire

### src/sfq_back.sv
// Request execution: ring storage, head/tail tracking, search and readout walks, result register.
`default_nettype none

module sfq_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_valid,
    output logic                                q_pop,
    input  sfq_pkg::req_t                       q_req,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [sfq_pkg::VALUE_W-1:0]  m_axis_tdata,   // value_out
    output logic [3:0]                          m_axis_tuser,   // status, found, now_empty
    output logic                                m_axis_tlast    // last
);
    import sfq_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] ring_mem [DEPTH];
    logic signed [VALUE_W-1:0] rd_data_reg;
    logic [AW-1:0]             rd_addr;
    logic                      mem_we;

    back_state_t               state_reg, state_next;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             tail_reg, tail_next;
    logic [CW-1:0]             occ_reg, occ_next;
    logic [AW-1:0]             ptr_reg, ptr_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic signed [VALUE_W-1:0] key_reg, key_next;

    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_found_reg;
    logic                      out_empty_reg;
    logic                      out_last_reg;

    logic                      slot_free;
    logic                      emit;
    status_t                   e_status;
    logic signed [VALUE_W-1:0] e_value;
    logic                      e_found;
    logic                      e_empty;
    logic                      e_last;
    logic                      hit;
    logic                      at_end;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        logic [AW-1:0] res;
        if (idx == AW'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign hit       = (rd_data_reg == key_reg);
    assign at_end    = (cnt_reg == CW'(occ_reg - 1'b1));

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        occ_next   = occ_reg;
        ptr_next   = ptr_reg;
        cnt_next   = cnt_reg;
        key_next   = key_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        rd_addr    = head_reg;
        emit       = 1'b0;
        e_status   = STAT_OK;
        e_value    = '0;
        e_found    = 1'b0;
        e_empty    = (occ_reg == '0);
        e_last     = 1'b1;

        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && slot_free)
                begin
                    q_pop = 1'b1;
                    case (q_req.kind)
                        REQ_ENQUEUE:
                        begin
                            emit    = 1'b1;
                            e_empty = 1'b0;
                            if (occ_reg == CW'(DEPTH))
                            begin
                                e_status = STAT_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                tail_next = ring_next(tail_reg);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                        REQ_DEQUEUE:
                        begin
                            if (occ_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = BK_DEQUEUE;
                            end
                        end
                        REQ_SEARCH:
                        begin
                            if (occ_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = STAT_EMPTY;
                                e_value  = q_req.value;
                            end
                            else
                            begin
                                key_next   = q_req.value;
                                ptr_next   = head_reg;
                                cnt_next   = '0;
                                state_next = BK_SEARCH;
                            end
                        end
                        REQ_READOUT:
                        begin
                            if (occ_reg == '0)
                            begin
                                emit     = 1'b1;
                                e_status = STAT_EMPTY;
                            end
                            else
                            begin
                                ptr_next   = head_reg;
                                cnt_next   = '0;
                                state_next = BK_READOUT;
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_DEQUEUE:
            begin
                // Keep the read address on the old head until the result is taken.
                rd_addr = head_reg;
                if (slot_free)
                begin
                    emit       = 1'b1;
                    e_value    = rd_data_reg;
                    e_empty    = (occ_reg == CW'(1));
                    head_next  = ring_next(head_reg);
                    occ_next   = occ_reg - 1'b1;
                    state_next = BK_IDLE;
                end
            end
            BK_SEARCH:
            begin
                rd_addr = ptr_reg;
                if (hit || at_end)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        e_status   = hit ? STAT_OK : STAT_NOT_FOUND;
                        e_value    = key_reg;
                        e_found    = hit;
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ring_next(ptr_reg);
                    cnt_next = cnt_reg + 1'b1;
                    rd_addr  = ring_next(ptr_reg);
                end
            end
            BK_READOUT:
            begin
                rd_addr = ptr_reg;
                if (slot_free)
                begin
                    emit    = 1'b1;
                    e_value = rd_data_reg;
                    e_last  = at_end;
                    if (at_end)
                    begin
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        ptr_next = ring_next(ptr_reg);
                        cnt_next = cnt_reg + 1'b1;
                        rd_addr  = ring_next(ptr_reg);
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[tail_reg] <= q_req.value;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (emit)
        begin
            out_status_reg <= e_status;
            out_value_reg  <= e_value;
            out_found_reg  <= e_found;
            out_empty_reg  <= e_empty;
            out_last_reg   <= e_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_value_reg;
    assign m_axis_tuser  = {out_empty_reg, out_found_reg, out_status_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

### src/searchable_fifo_queue_unit.sv
// Enqueues and empty reports go from the intake queue straight to the result register; dequeue,
// search and readout first read the ring through its registered read port. Throughput: enqueue
// 1 per cycle while the result stream is not stalled; a dequeue, search or readout takes no new
// request until its last result is registered; readout gives one result per cycle while the
// result stream is not stalled. The single ring read port paces the dequeue, search and readout walks.
// Reset: head, tail, occupancy and handshake state clear at once; ring contents
// are not cleared and no clearing pass runs, so requests are taken straight after reset.
`default_nettype none

module searchable_fifo_queue_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [sfq_pkg::VALUE_W-1:0]  s_axis_tdata,   // item_value
    input  logic [1:0]                          s_axis_tuser,   // req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [sfq_pkg::VALUE_W-1:0]  m_axis_tdata,   // value_out
    output logic [3:0]                          m_axis_tuser,   // status[1:0], found, now_empty
    output logic                                m_axis_tlast    // last
);
    import sfq_pkg::*;

    logic q_valid;
    logic q_pop;
    req_t q_req;

    sfq_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_req         (q_req)
    );

    sfq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .q_req         (q_req),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

### src/sfq_checker.sv
// Port-level checks on the result stream, bound to the top level.
`default_nettype none

module sfq_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic signed [sfq_pkg::VALUE_W-1:0]  m_axis_tdata,   // value_out
    input  logic [3:0]                          m_axis_tuser,   // status[1:0], found, now_empty
    input  logic                                m_axis_tlast    // last
);
    import sfq_pkg::*;

    // Hold a stalled result until it is taken.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1:0] == STAT_OK && m_axis_tlast)
        else $error("found flag without ok status");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == STAT_FULL |->
            !m_axis_tuser[3] && m_axis_tdata == '0 && m_axis_tlast)
        else $error("full report with bad fields");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == STAT_EMPTY |->
            m_axis_tuser[3] && !m_axis_tuser[2] && m_axis_tlast)
        else $error("empty report with bad fields");

endmodule

bind searchable_fifo_queue_unit sfq_checker u_sfq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

### verif/tb_searchable_fifo_queue_unit.sv
// Self-checking testbench for the searchable FIFO queue unit.
`timescale 1ns / 1ps

module tb_searchable_fifo_queue_unit;

    import sfq_pkg::*;

    localparam int unsigned DEPTH       = 16;
    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned RANDOM_REQS = 340;
    localparam int unsigned LONG_HOLD   = 250;

    typedef struct {
        status_t             status;
        logic signed [31:0]  value;
        logic                found;
        logic                now_empty;
        logic                last;
    } queue_result_t;

    // Mirror of the ring contents with the results each request should produce.
    class ring_tracker;
        logic signed [31:0] ring [DEPTH];
        int unsigned        head;
        int unsigned        tail;
        int unsigned        held;
        queue_result_t      due_results [$];
        int unsigned        errors;

        function new();
            head   = 0;
            tail   = 0;
            held   = 0;
            errors = 0;
        endfunction

        function void push_result(status_t status, logic signed [31:0] value,
                                  logic found, logic last);
            queue_result_t r;
            r.status    = status;
            r.value     = value;
            r.found     = found;
            r.now_empty = (held == 0);
            r.last      = last;
            due_results.push_back(r);
        endfunction

        function logic signed [31:0] entry_at(int unsigned k);
            return ring[(head + k) % DEPTH];
        endfunction

        function void take_request(req_kind_t kind, logic signed [31:0] value);
            int unsigned k;
            logic        hit;
            case (kind)
                REQ_ENQUEUE:
                begin
                    if (held >= DEPTH)
                    begin
                        push_result(STAT_FULL, 32'sd0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        ring[tail] = value;
                        tail = (tail + 1) % DEPTH;
                        held++;
                        push_result(STAT_OK, 32'sd0, 1'b0, 1'b1);
                    end
                end
                REQ_DEQUEUE:
                begin
                    if (held == 0)
                    begin
                        push_result(STAT_EMPTY, 32'sd0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        k = head;
                        head = (head + 1) % DEPTH;
                        held--;
                        push_result(STAT_OK, ring[k], 1'b0, 1'b1);
                    end
                end
                REQ_SEARCH:
                begin
                    hit = 1'b0;
                    for (k = 0; k < held; k++)
                    begin
                        if (entry_at(k) == value)
                        begin
                            hit = 1'b1;
                        end
                    end
                    if (held == 0)
                    begin
                        push_result(STAT_EMPTY, value, 1'b0, 1'b1);
                    end
                    else if (hit)
                    begin
                        push_result(STAT_OK, value, 1'b1, 1'b1);
                    end
                    else
                    begin
                        push_result(STAT_NOT_FOUND, value, 1'b0, 1'b1);
                    end
                end
                default:
                begin
                    if (held == 0)
                    begin
                        push_result(STAT_EMPTY, 32'sd0, 1'b0, 1'b1);
                    end
                    for (k = 0; k < held; k++)
                    begin
                        push_result(STAT_OK, entry_at(k), 1'b0, k + 1 == held);
                    end
                end
            endcase
        endfunction

        function void match_result(logic signed [31:0] tdata, logic [3:0] tuser,
                                   logic tlast);
            queue_result_t e;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result: value %h status %0d found %b empty %b last %b",
                         $time, tdata, tuser[1:0], tuser[2], tuser[3], tlast);
                errors++;
                return;
            end
            e = due_results.pop_front();
            if (tuser[1:0] != e.status)
            begin
                $display("%0t: status: expected %0d, actual %0d", $time, e.status, tuser[1:0]);
                errors++;
            end
            if (tdata != e.value)
            begin
                $display("%0t: value: expected %h, actual %h", $time, e.value, tdata);
                errors++;
            end
            if (tuser[2] != e.found)
            begin
                $display("%0t: found: expected %b, actual %b", $time, e.found, tuser[2]);
                errors++;
            end
            if (tuser[3] != e.now_empty)
            begin
                $display("%0t: now_empty: expected %b, actual %b",
                         $time, e.now_empty, tuser[3]);
                errors++;
            end
            if (tlast != e.last)
            begin
                $display("%0t: last: expected %b, actual %b", $time, e.last, tlast);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction
    endclass

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic signed [31:0] s_axis_tdata  = 32'sd0;
    logic [1:0]         s_axis_tuser  = REQ_ENQUEUE;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic signed [31:0] m_axis_tdata;
    logic [3:0]         m_axis_tuser;
    logic               m_axis_tlast;

    ring_tracker tracker = new();
    int unsigned quiet_cycles = 0;
    logic        hold_off_req = 1'b0;

    searchable_fifo_queue_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Observe both transfers at the rising edge and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                tracker.take_request(req_kind_t'(s_axis_tuser), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                tracker.match_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_searchable_fifo_queue_unit: done, errors");
                $finish;
            end
        end
    end

    function automatic int unsigned pick_gap(bit nonzero);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!nonzero && r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 2);
        end
        if (r < 96)
        begin
            return $urandom_range(3, 6);
        end
        return $urandom_range(15, 40);
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return $urandom_range(0, 7);
            3:       return -$signed(32'($urandom_range(1, 3)));
            default: return $urandom;
        endcase
    endfunction

    task automatic set_ready(logic level, int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            m_axis_tready = level;
        end
    endtask

    // Receiver: short bursts with stalls, calm stretches, and one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                set_ready(1'b0, LONG_HOLD);
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                set_ready(1'b1, $urandom_range(40, 80));
            end
            else
            begin
                set_ready(1'b1, $urandom_range(1, 12));
                set_ready(1'b0, pick_gap(1'b1));
            end
        end
    end

    task automatic idle(int unsigned cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = $urandom;
        end
    endtask

    // Call at a falling edge; hold the request until its transfer.
    task automatic drive_request(req_kind_t kind, logic signed [31:0] value);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = kind;
        s_axis_tdata  = value;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    task automatic send(req_kind_t kind, logic signed [31:0] value);
        idle(pick_gap(1'b0));
        @(negedge clk);
        drive_request(kind, value);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int unsigned        n;
        int unsigned        r;
        bit                 filling;
        req_kind_t          kind;
        logic signed [31:0] value;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty queue on every request that reads it.
        send(REQ_READOUT, $urandom);
        send(REQ_DEQUEUE, $urandom);
        send(REQ_SEARCH, 32'sh7fff_ffff);
        // Take the only entry back out, then fill the ring to the brim.
        send(REQ_ENQUEUE, 32'sh8000_0000);
        send(REQ_DEQUEUE, $urandom);
        for (n = 0; n < DEPTH; n++)
        begin
            case (n)
                0:       value = 32'sh7fff_ffff;
                1:       value = 32'sh8000_0000;
                2:       value = 32'sd0;
                3:       value = -32'sd1;
                4:       value = 32'sd1;
                default: value = $urandom;
            endcase
            send(REQ_ENQUEUE, value);
        end
        send(REQ_ENQUEUE, 32'sh5555_5555);
        send(REQ_SEARCH, tracker.entry_at(DEPTH - 1));
        send(REQ_SEARCH, 32'sh5555_5555);
        send(REQ_READOUT, $urandom);

        filling = 1'b0;
        for (n = 0; n < RANDOM_REQS; n++)
        begin
            if (n == 120)
            begin
                hold_off_req = 1'b1;
            end
            if (n == 240)
            begin
                pause_until_drained();
            end
            idle((n >= 60 && n < 110) ? 0 : pick_gap(1'b0));
            @(negedge clk);
            // Wander between empty and full, lingering at both ends.
            if (tracker.held == DEPTH && $urandom_range(0, 2) == 0)
            begin
                filling = 1'b0;
            end
            else if (tracker.held == 0 && $urandom_range(0, 2) == 0)
            begin
                filling = 1'b1;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                filling = !filling;
            end
            r = $urandom_range(0, 99);
            value = pick_value();
            if (r < 14)
            begin
                kind = REQ_SEARCH;
                if (tracker.held != 0 && $urandom_range(0, 1) == 0)
                begin
                    value = tracker.entry_at($urandom_range(0, tracker.held - 1));
                end
            end
            else if (r < 21)
            begin
                kind = REQ_READOUT;
            end
            else if ($urandom_range(0, 3) < (filling ? 3 : 1))
            begin
                kind = REQ_ENQUEUE;
            end
            else
            begin
                kind = REQ_DEQUEUE;
            end
            drive_request(kind, value);
        end

        pause_until_drained();
        repeat (20) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("tb_searchable_fifo_queue_unit: done, clean");
        end
        else
        begin
            $display("tb_searchable_fifo_queue_unit: done, errors");
        end
        $finish;
    end

endmodule

### searchable_fifo_queue_unit.f
src/sfq_pkg.sv
src/sfq_front.sv
src/sfq_back.sv
src/searchable_fifo_queue_unit.sv
src/sfq_checker.sv
verif/tb_searchable_fifo_queue_unit.sv
